### hdl/triangle_unit_normal_unit_macros.svh
// ---------------------------------------------------------------------------
// assertion macros for the triangle unit normal block
// ---------------------------------------------------------------------------
`ifndef TRIANGLE_UNIT_NORMAL_UNIT_MACROS_SVH
`define TRIANGLE_UNIT_NORMAL_UNIT_MACROS_SVH

// implication checked every clock outside reset
`define TUN_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tun assertion failed");

// implication checked in the clock after the antecedent
`define TUN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tun assertion failed");

`endif

### hdl/tun_pkg.sv
// ---------------------------------------------------------------------------
// tun_pkg
// shared constants for the triangle unit normal pipeline
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package tun_pkg;
  localparam int COORD_BITS_DEF  = 24;
  localparam int NORMAL_BITS_DEF = 16;
  // edge magnitudes are kept below 2^25, cross magnitudes below 2^31
  localparam int EDGE_W  = 25;
  localparam int CROSS_W = 31;
  localparam int SUM_W   = 64;
  localparam int LEN_W   = 32;
endpackage

### hdl/tun_div.sv
// ---------------------------------------------------------------------------
// tun_div
// pipelined restoring divider, one quotient bit per stage, with stall
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tun_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 32,
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [NUM_W-1:0] quo,
  output logic [TAG_W-1:0] out_tag
);
  logic             vld [NUM_W+1];
  logic [NUM_W-1:0] nq  [NUM_W+1];
  logic [DEN_W:0]   rem [NUM_W+1];
  logic [DEN_W-1:0] dv  [NUM_W+1];
  logic [TAG_W-1:0] tg  [NUM_W+1];

  assign vld[0] = in_valid;
  assign nq[0]  = num;
  assign rem[0] = '0;
  assign dv[0]  = den;
  assign tg[0]  = in_tag;

  // one quotient bit per stage, numerator shifts into the remainder
  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic [DEN_W+1:0] trial;
    logic [DEN_W+1:0] sub;
    assign trial = {rem[i], nq[i][NUM_W-1]};
    assign sub   = trial - {2'b00, dv[i]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!sub[DEN_W+1]) begin
          rem[i+1] <= sub[DEN_W:0];
          nq[i+1]  <= {nq[i][NUM_W-2:0], 1'b1};
        end else begin
          rem[i+1] <= trial[DEN_W:0];
          nq[i+1]  <= {nq[i][NUM_W-2:0], 1'b0};
        end
        dv[i+1] <= dv[i];
        tg[i+1] <= tg[i];
      end
    end
  end

  assign out_valid = vld[NUM_W];
  assign quo       = nq[NUM_W];
  assign out_tag   = tg[NUM_W];
endmodule

### hdl/tun_sqrt.sv
// ---------------------------------------------------------------------------
// tun_sqrt
// pipelined integer square root, one result bit per stage, with stall
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tun_sqrt #(
  parameter int IN_W  = 64,
  parameter int TAG_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [IN_W-1:0]   rad,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_valid,
  output logic [IN_W/2-1:0] root,
  output logic [TAG_W-1:0]  out_tag
);
  localparam int N = IN_W / 2;
  logic            vld [N+1];
  logic [IN_W-1:0] rd  [N+1];
  logic [N+1:0]    rm  [N+1];
  logic [N-1:0]    rt  [N+1];
  logic [TAG_W-1:0] tg [N+1];

  assign vld[0] = in_valid;
  assign rd[0]  = rad;
  assign rm[0]  = '0;
  assign rt[0]  = '0;
  assign tg[0]  = in_tag;

  // digit-by-digit root: bring down two bits, try 4r+1
  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [N+3:0] trial;
    logic [N+3:0] sub;
    assign trial = {rm[i], rd[i][IN_W-1:IN_W-2]};
    assign sub   = trial - {2'b00, rt[i], 2'b01};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!sub[N+3]) begin
          rm[i+1] <= sub[N+1:0];
          rt[i+1] <= {rt[i][N-2:0], 1'b1};
        end else begin
          rm[i+1] <= trial[N+1:0];
          rt[i+1] <= {rt[i][N-2:0], 1'b0};
        end
        rd[i+1] <= {rd[i][IN_W-3:0], 2'b00};
        tg[i+1] <= tg[i];
      end
    end
  end

  assign out_valid = vld[N];
  assign root      = rt[N];
  assign out_tag   = tg[N];
endmodule

### hdl/triangle_unit_normal_unit.sv
// ---------------------------------------------------------------------------
// triangle_unit_normal_unit
// unit face normal of a triangle: cross product, length and three divides
// ---------------------------------------------------------------------------
// channel  dir  fields (low bit up)
// s_axis   in   tdata: v0_x v0_y v0_z v1_x v1_y v1_z v2_x v2_y v2_z
// m_axis   out  tdata: normal_x normal_y normal_z ; tuser: degenerate
//
// one transaction per cycle sustained while the output is not stalled; the result
// passes through seven front stages, the 32-stage square root, the
// CROSS_W+NORMAL_BITS divider stages and the output register.
// the whole pipeline advances when the output register is empty or taken;
// a stall freezes every stage, so nothing is lost or repeated.
// rst clears the valid bits only.
`timescale 1ns / 1ps
`include "triangle_unit_normal_unit_macros.svh"
module triangle_unit_normal_unit #(
  parameter int COORD_BITS  = tun_pkg::COORD_BITS_DEF,
  parameter int NORMAL_BITS = tun_pkg::NORMAL_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // v0_x v0_y v0_z v1_x v1_y v1_z v2_x v2_y v2_z, COORD_BITS each
  input  logic [((9*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // normal_x normal_y normal_z, NORMAL_BITS each
  output logic [((3*NORMAL_BITS+7)/8)*8-1:0] m_axis_tdata,
  // degenerate
  output logic m_axis_tuser
);
  import tun_pkg::*;

  localparam int DW    = COORD_BITS + 1;
  localparam int SH_W  = (DW > EDGE_W) ? $clog2(DW - EDGE_W + 1) : 1;
  localparam int PW    = 2 * EDGE_W;
  localparam int CW    = PW + 1;
  localparam int T_W   = $clog2(CW - CROSS_W + 1);
  localparam int NUM_W = CROSS_W + NORMAL_BITS;
  localparam int OW    = ((3*NORMAL_BITS+7)/8)*8;
  localparam logic [NORMAL_BITS:0] POSMAX = {2'b00, {(NORMAL_BITS-1){1'b1}}};
  localparam logic [NORMAL_BITS:0] NEGMAX = {2'b01, {(NORMAL_BITS-1){1'b0}}};

  logic en;

  // stage 1: edges as sign and magnitude
  logic s1_v;
  logic [DW-1:0] s1_mag [6];
  logic          s1_neg [6];
  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (en) s1_v <= s_axis_tvalid;
  end
  for (genvar i = 0; i < 3; i++) begin : g_edge
    logic signed [COORD_BITS-1:0] a, b, c;
    logic signed [DW-1:0] du, dw;
    assign a  = s_axis_tdata[i*COORD_BITS +: COORD_BITS];
    assign b  = s_axis_tdata[(3+i)*COORD_BITS +: COORD_BITS];
    assign c  = s_axis_tdata[(6+i)*COORD_BITS +: COORD_BITS];
    assign du = DW'(b) - DW'(a);
    assign dw = DW'(c) - DW'(a);
    always_ff @(posedge clk) begin
      if (en) begin
        s1_neg[i]   <= du[DW-1];
        s1_mag[i]   <= du[DW-1] ? DW'(-du) : DW'(du);
        s1_neg[3+i] <= dw[DW-1];
        s1_mag[3+i] <= dw[DW-1] ? DW'(-dw) : DW'(dw);
      end
    end
  end

  // stage 2: common prescale of edges below 2^25, back to signed
  logic s2_v;
  logic signed [EDGE_W:0] s2_e [6];
  logic [DW-1:0] s1_or;
  logic [SH_W-1:0] s1_sh;
  always_comb begin
    s1_or = '0;
    for (int i = 0; i < 6; i++) s1_or = s1_or | s1_mag[i];
    s1_sh = '0;
    for (int k = 0; k < DW; k++)
      if (k >= EDGE_W && s1_or[k]) s1_sh = SH_W'(k - EDGE_W + 1);
  end
  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (en) s2_v <= s1_v;
  end
  for (genvar i = 0; i < 6; i++) begin : g_pre
    logic [DW-1:0] sm;
    logic [EDGE_W:0] m;
    assign sm = s1_mag[i] >> s1_sh;
    if (DW >= EDGE_W + 1) begin : g_tr
      assign m = sm[EDGE_W:0];
    end else begin : g_ex
      assign m = (EDGE_W+1)'(sm);
    end
    always_ff @(posedge clk) begin
      if (en) s2_e[i] <= s1_neg[i] ? -$signed(m) : $signed(m);
    end
  end

  // stage 3: six products
  logic s3_v;
  logic signed [PW+1:0] s3_p [6];
  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (en) s3_v <= s2_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s3_p[0] <= s2_e[1] * s2_e[5];
      s3_p[1] <= s2_e[2] * s2_e[4];
      s3_p[2] <= s2_e[2] * s2_e[3];
      s3_p[3] <= s2_e[0] * s2_e[5];
      s3_p[4] <= s2_e[0] * s2_e[4];
      s3_p[5] <= s2_e[1] * s2_e[3];
    end
  end

  // stage 4: cross components as sign and magnitude
  logic s4_v;
  logic [CW-1:0] s4_mag [3];
  logic          s4_neg [3];
  always_ff @(posedge clk) begin
    if (rst) s4_v <= 1'b0;
    else if (en) s4_v <= s3_v;
  end
  for (genvar i = 0; i < 3; i++) begin : g_cross
    logic signed [PW+1:0] d;
    assign d = s3_p[2*i] - s3_p[2*i+1];
    always_ff @(posedge clk) begin
      if (en) begin
        s4_neg[i] <= d[PW+1];
        s4_mag[i] <= d[PW+1] ? CW'(-d) : CW'(d);
      end
    end
  end

  // stage 5: prescale cross below 2^31, flag zero
  logic s5_v, s5_deg;
  logic [CROSS_W-1:0] s5_m [3];
  logic s5_neg [3];
  logic [CW-1:0] s4_or;
  logic [T_W-1:0] s4_sh;
  always_comb begin
    s4_or = s4_mag[0] | s4_mag[1] | s4_mag[2];
    s4_sh = '0;
    for (int k = CROSS_W; k < CW; k++)
      if (s4_or[k]) s4_sh = T_W'(k - CROSS_W + 1);
  end
  always_ff @(posedge clk) begin
    if (rst) s5_v <= 1'b0;
    else if (en) s5_v <= s4_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s5_deg <= (s4_or == '0);
      for (int i = 0; i < 3; i++) begin
        s5_m[i]   <= CROSS_W'(s4_mag[i] >> s4_sh);
        s5_neg[i] <= s4_neg[i];
      end
    end
  end

  // stage 6: squares
  logic s6_v;
  logic [2*CROSS_W-1:0] s6_sq [3];
  logic [CROSS_W-1:0] s6_m [3];
  logic [3:0] s6_fl;
  always_ff @(posedge clk) begin
    if (rst) s6_v <= 1'b0;
    else if (en) s6_v <= s5_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s6_sq[i] <= s5_m[i] * s5_m[i];
        s6_m[i]  <= s5_m[i];
      end
      s6_fl <= {s5_deg, s5_neg[2], s5_neg[1], s5_neg[0]};
    end
  end

  // stage 7: sum of squares
  localparam int TAG_W = 3*CROSS_W + 4;
  logic s7_v;
  logic [SUM_W-1:0] s7_sum;
  logic [TAG_W-1:0] s7_tag;
  always_ff @(posedge clk) begin
    if (rst) s7_v <= 1'b0;
    else if (en) s7_v <= s6_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s7_sum <= SUM_W'(s6_sq[0]) + SUM_W'(s6_sq[1]) + SUM_W'(s6_sq[2]);
      s7_tag <= {s6_fl, s6_m[2], s6_m[1], s6_m[0]};
    end
  end

  // square root pipeline
  logic sq_v;
  logic [LEN_W-1:0] sq_root;
  logic [TAG_W-1:0] sq_tag;
  tun_sqrt #(.IN_W(SUM_W), .TAG_W(TAG_W)) u_sqrt (
    .clk, .rst, .en,
    .in_valid(s7_v), .rad(s7_sum), .in_tag(s7_tag),
    .out_valid(sq_v), .root(sq_root), .out_tag(sq_tag)
  );

  // three dividers: (|c| << (NORMAL_BITS-1) + L/2) / L
  // one spare top bit keeps the rounding term from overflowing
  logic [LEN_W-1:0] len;
  assign len = (sq_root == '0) ? LEN_W'(1) : sq_root;
  logic dv_v [3];
  logic [NUM_W-1:0] dq [3];
  logic [3:0] dtag [3];
  for (genvar i = 0; i < 3; i++) begin : g_div
    logic [NUM_W-1:0] num;
    assign num = {1'b0, sq_tag[i*CROSS_W +: CROSS_W], {(NORMAL_BITS-1){1'b0}}}
               + NUM_W'(len >> 1);
    tun_div #(.NUM_W(NUM_W), .DEN_W(LEN_W), .TAG_W(4)) u_div (
      .clk, .rst, .en,
      .in_valid(sq_v), .num(num), .den(len), .in_tag(sq_tag[TAG_W-1 -: 4]),
      .out_valid(dv_v[i]), .quo(dq[i]), .out_tag(dtag[i])
    );
  end

  // output register: saturate and sign
  logic [NORMAL_BITS-1:0] onorm [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [NORMAL_BITS:0] q;
      q = (dq[i] > NUM_W'(NEGMAX)) ? NEGMAX : dq[i][NORMAL_BITS:0];
      if (dtag[0][3]) onorm[i] = '0;
      else if (dtag[0][i]) onorm[i] = NORMAL_BITS'(-q);
      else onorm[i] = (q > POSMAX) ? POSMAX[NORMAL_BITS-1:0] : q[NORMAL_BITS-1:0];
    end
  end
  logic [OW-1:0] out_data;
  logic out_deg;
  assign en = !m_axis_tvalid || m_axis_tready;
  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (en) m_axis_tvalid <= dv_v[0];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= OW'({onorm[2], onorm[1], onorm[0]});
      out_deg  <= dtag[0][3];
    end
  end
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_deg;
  assign s_axis_tready = en;

  // checks
  `TUN_ASSERT_IMPL(a_lanes_agree, 1'b1, dv_v[0] == dv_v[1] && dv_v[1] == dv_v[2])
  `TUN_ASSERT_IMPL(a_deg_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)
  `TUN_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata))
endmodule

### dv/tb_triangle_unit_normal_unit.sv
// ---------------------------------------------------------------------------
// tb_triangle_unit_normal_unit
// streams triangles into the unit normal block and checks every normal and
// degenerate flag against a behavioral prediction, with random stalls
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_triangle_unit_normal_unit;
  localparam int CB  = tun_pkg::COORD_BITS_DEF;
  localparam int NB  = tun_pkg::NORMAL_BITS_DEF;
  localparam int IW  = ((9*CB+7)/8)*8;
  localparam int OW  = ((3*NB+7)/8)*8;
  localparam int LAT = 3*NB + 60;

  typedef logic signed [CB-1:0] coord_t;
  typedef struct packed {
    logic signed [NB-1:0] nz;
    logic signed [NB-1:0] ny;
    logic signed [NB-1:0] nx;
    logic                 degen;
  } normal_t;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [IW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [OW-1:0] m_axis_tdata;
  logic m_axis_tuser;

  normal_t expected_normals[$];
  int  errors = 0;
  bit  no_idle = 0;
  bit  hold_sink = 0;

  always #5 clk = ~clk;

  triangle_unit_normal_unit i_dut (.*);

  // integer square root, bit by bit
  function automatic logic [63:0] isqrt(logic [63:0] s);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // expected unit normal of one triangle
  function automatic normal_t face_normal(coord_t v[9]);
    normal_t n;
    logic signed [63:0] e[6];
    logic signed [63:0] c[3];
    logic [63:0] m[3];
    logic [63:0] mx, sum, len, q;
    for (int i = 0; i < 3; i++) begin
      e[i]   = 64'(v[3+i]) - 64'(v[i]);
      e[3+i] = 64'(v[6+i]) - 64'(v[i]);
    end
    c[0] = e[1]*e[5] - e[2]*e[4];
    c[1] = e[2]*e[3] - e[0]*e[5];
    c[2] = e[0]*e[4] - e[1]*e[3];
    n = '0;
    if (c[0] == 0 && c[1] == 0 && c[2] == 0) begin
      n.degen = 1;
      return n;
    end
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = c[i] < 0 ? -c[i] : c[i];
      if (m[i] > mx) mx = m[i];
    end
    while (mx >= (64'd1 << 31)) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    end
    sum = m[0]*m[0] + m[1]*m[1] + m[2]*m[2];
    len = isqrt(sum);
    if (len == 0) len = 1;
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << (NB-1)) + (len >> 1)) / len;
      if (c[i] < 0) begin
        if (q > (64'd1 << (NB-1))) q = 64'd1 << (NB-1);
        q = -q;
      end else if (q > (64'd1 << (NB-1)) - 1) begin
        q = (64'd1 << (NB-1)) - 1;
      end
      if (i == 0) n.nx = q[NB-1:0];
      else if (i == 1) n.ny = q[NB-1:0];
      else n.nz = q[NB-1:0];
    end
    return n;
  endfunction

  // send one triangle; valid stays up until the next idle cycle or stop
  task automatic send_triangle(coord_t v[9]);
    logic [IW-1:0] d;
    d = '0;
    for (int i = 0; i < 9; i++) d[i*CB +: CB] = v[i];
    while (!no_idle && $urandom_range(99) < 22) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tdata  <= d;
    s_axis_tvalid <= 1;
    do @(posedge clk); while (!s_axis_tready);
    expected_normals = {expected_normals, face_normal(v)};
  endtask

  // drop valid after the last transaction
  task automatic stop_sending();
    s_axis_tvalid <= 0;
    @(posedge clk);
  endtask

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'(int'($urandom_range(0, 4095)) - 2048);
      2: return $urandom_range(1) ? coord_t'({1'b0, {(CB-1){1'b1}}})
                                  : coord_t'({1'b1, {(CB-1){1'b0}}});
      default: return coord_t'(int'($urandom_range(0, 63)) - 32);
    endcase
  endfunction

  // receiver with random stalls
  always @(posedge clk) begin
    if (rst || hold_sink) m_axis_tready <= 0;
    else m_axis_tready <= no_idle || ($urandom_range(99) >= 22);
  end

  // result check
  always @(posedge clk) begin
    normal_t got, exp_n;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[3*NB-1:0], m_axis_tuser};
      if (expected_normals.size() == 0) begin
        $display("%0t unexpected normal: actual %h", $time, got);
        errors++;
      end else begin
        exp_n = expected_normals.pop_front();
        if (got.nx !== exp_n.nx) begin
          $display("%0t normal_x expected %0d actual %0d", $time, exp_n.nx, got.nx);
          errors++;
        end
        if (got.ny !== exp_n.ny) begin
          $display("%0t normal_y expected %0d actual %0d", $time, exp_n.ny, got.ny);
          errors++;
        end
        if (got.nz !== exp_n.nz) begin
          $display("%0t normal_z expected %0d actual %0d", $time, exp_n.nz, got.nz);
          errors++;
        end
        if (got.degen !== exp_n.degen) begin
          $display("%0t degenerate expected %0d actual %0d", $time, exp_n.degen, got.degen);
          errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    stop_sending();
    while (expected_normals.size() != 0) @(posedge clk);
  endtask

  // extremes, degenerate and saturating cases
  task automatic test_directed();
    coord_t v[9];
    coord_t mx, mn;
    mx = {1'b0, {(CB-1){1'b1}}};
    mn = {1'b1, {(CB-1){1'b0}}};
    v = '{default: 0};
    send_triangle(v);                          // all zero: degenerate
    v = '{0,0,0, 4096,0,0, 0,4096,0};          // unit z normal, saturates
    send_triangle(v);
    v = '{0,0,0, 0,4096,0, 4096,0,0};          // negative z, -1.0
    send_triangle(v);
    v = '{0,0,0, 0,0,4096, 4096,0,0};
    send_triangle(v);
    v = '{0,0,0, 0,4096,0, 0,0,4096};
    send_triangle(v);
    v = '{1,1,1, 2,2,2, 3,3,3};                // collinear: degenerate
    send_triangle(v);
    v = '{mn,mn,mn, mx,mn,mn, mn,mx,mn};       // largest edges
    send_triangle(v);
    v = '{mx,mx,mx, mn,mx,mx, mx,mn,mx};
    send_triangle(v);
    v = '{mn,mx,mn, mx,mn,mx, mx,mx,mn};
    send_triangle(v);
    v = '{mx,mx,mx, mn,mn,mn, mx,mn,mx};
    send_triangle(v);
    v = '{0,0,0, 1,0,0, 0,1,0};                // smallest area
    send_triangle(v);
    v = '{0,0,0, 1,1,0, 1,0,1};
    send_triangle(v);
    v = '{0,0,0, -1,-1,-1, 1,-1,0};
    send_triangle(v);
    for (int i = 0; i < 9; i++) v[i] = mx;
    send_triangle(v);
    for (int i = 0; i < 9; i++) v[i] = mn;
    send_triangle(v);
  endtask

  task automatic test_random(int count);
    coord_t v[9];
    int mode;
    for (int k = 0; k < count; k++) begin
      mode = $urandom_range(3);
      for (int i = 0; i < 9; i++) v[i] = rand_coord(mode);
      if ($urandom_range(19) == 0) begin           // force collinear
        for (int i = 0; i < 3; i++) v[6+i] = v[3+i];
      end
      send_triangle(v);
    end
  endtask

  // receiver holds off while triangles keep coming
  task automatic test_backpressure();
    hold_sink = 1;
    fork
      begin
        repeat (LAT + 200) @(posedge clk);
        hold_sink = 0;
      end
      begin
        test_random(LAT + 60);
        stop_sending();
      end
    join
  endtask

  task automatic test_burst();
    no_idle = 1;
    test_random(150);
    no_idle = 0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    wait_drained();
    test_random(350);
    test_backpressure();
    test_burst();
    wait_drained();
    test_random(200);
    wait_drained();
    repeat (LAT + 20) @(posedge clk);
    if (errors == 0) $display("triangle_unit_normal_unit: match");
    else $display("triangle_unit_normal_unit: mismatch");
    $finish;
  end

  initial begin
    #5ms;
    $display("triangle_unit_normal_unit: mismatch");
    $finish;
  end
endmodule
